// ===== design/sphc_pkg.sv =====
// sphc_pkg: shared types and constants for the soil pump hysteresis controller.
// Holds the sample and result beat structs, register index codes and fixed constants.
// No dependencies.
package sphc_pkg;

    // Configuration register index codes
    typedef enum logic [2:0] {
        REG_MOISTURE_MIN   = 3'd0,
        REG_NITROGEN_MIN   = 3'd1,
        REG_PHOSPHORUS_MIN = 3'd2,
        REG_POTASSIUM_MIN  = 3'd3,
        REG_MOISTURE_BAND  = 3'd4,
        REG_NUTRIENT_BAND  = 3'd5,
        REG_PH_LOW_TENTHS  = 3'd6,
        REG_PH_HIGH_TENTHS = 3'd7
    } cfg_index_t;

    localparam int CFG_DATA_W = 9;

    // Register reset values
    localparam logic [6:0] MOISTURE_MIN_RST   = 7'd60;
    localparam logic [8:0] NITROGEN_MIN_RST   = 9'd100;
    localparam logic [8:0] PHOSPHORUS_MIN_RST = 9'd50;
    localparam logic [8:0] POTASSIUM_MIN_RST  = 9'd100;
    localparam logic [6:0] MOISTURE_BAND_RST  = 7'd10;
    localparam logic [8:0] NUTRIENT_BAND_RST  = 9'd30;
    localparam logic [7:0] PH_LOW_RST         = 8'd50;
    localparam logic [7:0] PH_HIGH_RST        = 8'd80;

    // Scaling: level = raw * full / RAW_FULL
    localparam logic [11:0] RAW_FULL  = 12'd4095;
    localparam logic [8:0]  FULL_PCT  = 9'd100;
    localparam logic [8:0]  FULL_PH   = 9'd140;
    localparam logic [8:0]  FULL_NUT  = 9'd500;

    // Servo sweep
    localparam logic [7:0] SWEEP_STEP = 8'd15;
    localparam logic [7:0] ANGLE_MAX  = 8'd180;
    localparam logic [7:0] ANGLE_PARK = 8'd90;
    localparam logic [9:0] PULSE_MIN  = 10'd150;
    localparam logic [9:0] PULSE_PARK = 10'd375;
    localparam logic [9:0] PULSE_X2_PER_DEG = 10'd5;  // 450/180 = 5/2

    // Pump numbering
    localparam int NUM_PUMPS  = 4;
    localparam int PUMP_WATER = 0;

    typedef struct packed {
        logic [11:0] raw_moisture;
        logic [11:0] raw_acidity;
        logic [11:0] raw_nitrogen;
        logic [11:0] raw_phosphorus;
        logic [11:0] raw_potassium;
    } sample_t;

    typedef struct packed {
        logic [6:0] moisture_pct;
        logic [7:0] acidity_tenths;
        logic [8:0] nitrogen_level;
        logic [8:0] phosphorus_level;
        logic [8:0] potassium_level;
        logic       alarm_on;
        logic [3:0] pump_flags;
        logic [9:0] water_pulse;
        logic [9:0] nitrogen_pulse;
        logic [9:0] phosphorus_pulse;
        logic [9:0] potassium_pulse;
    } result_t;

endpackage

// ===== design/soil_pump_hysteresis_controller.sv =====
// soil_pump_hysteresis_controller: top level, scaling, pH interlock and pump sweep.
// Depends on sphc_pkg (beat structs, register codes, constants).

// One sample beat carries five 12-bit converter readings. Each beat is scaled
// (moisture to percent, pH to tenths, N/P/K to mg/kg), the pH window check
// raises alarm_on, and four on/off pumps with hysteresis update their flags
// and servo sweep. While the alarm is up the three nutrient pumps are forced
// off, their pulses read 375 and their sweep angle and direction hold.
// Timing: a sample beat lands in an input register, passes one stage of
// constant-coefficient scaling and compare logic, and is held in the result
// register, from which the result is offered.
// One sample is taken every cycle as long as the result side keeps up; the
// result register can stall while the input register still holds one more
// beat. Pump state updates as the beat moves into the result register, so
// each beat sees the state left by the one before it.
// Configuration writes are always accepted (cfg_ready is high) and take
// effect on the next beat; write them only while no beat is in flight.
module soil_pump_hysteresis_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    // sample channel
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  sphc_pkg::sample_t              sample,
    // result channel
    output logic                           result_valid,
    input  logic                           result_ready,
    output sphc_pkg::result_t              result,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  sphc_pkg::cfg_index_t           cfg_index,
    input  logic [sphc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sphc_pkg::*;

    // ------------------------------------------------------------------
    // Scaling by constant over 4095: x = raw*full; q0 = x>>12 underestimates
    // by at most one, since x - 4095*q0 = x[11:0] + q0 < 2*4095.
    // ------------------------------------------------------------------
    function automatic logic [8:0] scale_raw(input logic [11:0] raw, input logic [8:0] full);
        logic [20:0] prod;
        logic [8:0]  q0;
        logic [12:0] rem;
        prod = 21'(raw) * 21'(full);
        q0   = prod[20:12];
        rem  = 13'(prod[11:0]) + 13'(q0);
        return (rem >= 13'(RAW_FULL)) ? q0 + 9'd1 : q0;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [6:0] moisture_min_reg;
    logic [8:0] nitrogen_min_reg;
    logic [8:0] phosphorus_min_reg;
    logic [8:0] potassium_min_reg;
    logic [6:0] moisture_band_reg;
    logic [8:0] nutrient_band_reg;
    logic [7:0] ph_low_reg;
    logic [7:0] ph_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moisture_min_reg   <= MOISTURE_MIN_RST;
            nitrogen_min_reg   <= NITROGEN_MIN_RST;
            phosphorus_min_reg <= PHOSPHORUS_MIN_RST;
            potassium_min_reg  <= POTASSIUM_MIN_RST;
            moisture_band_reg  <= MOISTURE_BAND_RST;
            nutrient_band_reg  <= NUTRIENT_BAND_RST;
            ph_low_reg         <= PH_LOW_RST;
            ph_high_reg        <= PH_HIGH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MOISTURE_MIN:   moisture_min_reg   <= cfg_data[6:0];
                REG_NITROGEN_MIN:   nitrogen_min_reg   <= cfg_data[8:0];
                REG_PHOSPHORUS_MIN: phosphorus_min_reg <= cfg_data[8:0];
                REG_POTASSIUM_MIN:  potassium_min_reg  <= cfg_data[8:0];
                REG_MOISTURE_BAND:  moisture_band_reg  <= cfg_data[6:0];
                REG_NUTRIENT_BAND:  nutrient_band_reg  <= cfg_data[8:0];
                REG_PH_LOW_TENTHS:  ph_low_reg         <= cfg_data[7:0];
                REG_PH_HIGH_TENTHS: ph_high_reg        <= cfg_data[7:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register and result register handshake
    // ------------------------------------------------------------------
    logic    in_valid_reg;
    sample_t in_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    advance;
    result_t out_data_next;

    // beat moves from the input register to the result register
    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_ready)
                in_valid_reg <= sample_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
            in_data_reg <= sample;
        if (advance)
            out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // ------------------------------------------------------------------
    // Scaling and pH interlock
    // ------------------------------------------------------------------
    logic [8:0] moist_s;
    logic [8:0] ph_s;
    logic [8:0] nit_s;
    logic [8:0] phos_s;
    logic [8:0] pot_s;
    logic       alarm;

    assign moist_s = scale_raw(in_data_reg.raw_moisture,   FULL_PCT);
    assign ph_s    = scale_raw(in_data_reg.raw_acidity,    FULL_PH);
    assign nit_s   = scale_raw(in_data_reg.raw_nitrogen,   FULL_NUT);
    assign phos_s  = scale_raw(in_data_reg.raw_phosphorus, FULL_NUT);
    assign pot_s   = scale_raw(in_data_reg.raw_potassium,  FULL_NUT);

    // inverted window is applied as it stands
    assign alarm = (ph_s < 9'(ph_low_reg)) || (ph_s > 9'(ph_high_reg));

    // per-pump operands, index 0 water, 1 N, 2 P, 3 K
    logic [8:0] level [NUM_PUMPS];
    logic [8:0] minv  [NUM_PUMPS];
    logic [8:0] band  [NUM_PUMPS];

    assign level[0] = moist_s;
    assign level[1] = nit_s;
    assign level[2] = phos_s;
    assign level[3] = pot_s;
    assign minv[0]  = 9'(moisture_min_reg);
    assign minv[1]  = nitrogen_min_reg;
    assign minv[2]  = phosphorus_min_reg;
    assign minv[3]  = potassium_min_reg;
    assign band[0]  = 9'(moisture_band_reg);
    assign band[1]  = nutrient_band_reg;
    assign band[2]  = nutrient_band_reg;
    assign band[3]  = nutrient_band_reg;

    // ------------------------------------------------------------------
    // Pump lanes: hysteresis, sweep and pulse
    // ------------------------------------------------------------------
    logic       active_reg  [NUM_PUMPS];
    logic [7:0] angle_reg   [NUM_PUMPS];
    logic       falling_reg [NUM_PUMPS];
    logic [NUM_PUMPS-1:0] flag_next;
    logic [9:0] pulse_next  [NUM_PUMPS];

    for (genvar k = 0; k < NUM_PUMPS; k++)
    begin : g_pump
        logic               interlocked;
        logic [9:0]         limit;
        logic               act_new;
        logic signed [9:0]  stepped;
        logic               active_next;
        logic [7:0]         angle_next;
        logic               falling_next;
        logic [9:0]         angle_x5;

        // nutrient lanes stop and freeze while the alarm is up
        assign interlocked = alarm && (k != PUMP_WATER);
        assign limit       = 10'(minv[k]) + 10'(band[k]);

        always_comb
        begin
            if (level[k] < minv[k])
                act_new = 1'b1;
            else if (10'(level[k]) > limit)
                act_new = 1'b0;
            else
                act_new = active_reg[k];
        end

        assign stepped = falling_reg[k]
                         ? $signed(10'(angle_reg[k]) - 10'(SWEEP_STEP))
                         : $signed(10'(angle_reg[k]) + 10'(SWEEP_STEP));

        always_comb
        begin
            active_next  = act_new;
            angle_next   = angle_reg[k];
            falling_next = falling_reg[k];
            if (interlocked)
                active_next = 1'b0;
            else if (act_new)
            begin
                if (stepped >= $signed(10'(ANGLE_MAX)))
                begin
                    angle_next   = ANGLE_MAX;
                    falling_next = 1'b1;
                end
                else if (stepped <= 10'sd0)
                begin
                    angle_next   = 8'd0;
                    falling_next = 1'b0;
                end
                else
                    angle_next = stepped[7:0];
            end
            else
                angle_next = ANGLE_PARK;
        end

        // pulse = 150 + angle*5/2, truncated
        assign angle_x5      = 10'(angle_next) * PULSE_X2_PER_DEG;
        assign pulse_next[k] = active_next ? PULSE_MIN + (angle_x5 >> 1) : PULSE_PARK;
        assign flag_next[k]  = active_next;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                active_reg[k]  <= 1'b0;
                angle_reg[k]   <= ANGLE_PARK;
                falling_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                active_reg[k]  <= active_next;
                angle_reg[k]   <= angle_next;
                falling_reg[k] <= falling_next;
            end
        end
    end

    always_comb
    begin
        out_data_next.moisture_pct     = moist_s[6:0];
        out_data_next.acidity_tenths   = ph_s[7:0];
        out_data_next.nitrogen_level   = nit_s;
        out_data_next.phosphorus_level = phos_s;
        out_data_next.potassium_level  = pot_s;
        out_data_next.alarm_on         = alarm;
        out_data_next.pump_flags       = flag_next;
        out_data_next.water_pulse      = pulse_next[0];
        out_data_next.nitrogen_pulse   = pulse_next[1];
        out_data_next.phosphorus_pulse = pulse_next[2];
        out_data_next.potassium_pulse  = pulse_next[3];
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_alarm_clears_dosers: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.alarm_on |->
            result.pump_flags[3:1] == 3'b000 &&
            result.nitrogen_pulse == PULSE_PARK &&
            result.phosphorus_pulse == PULSE_PARK &&
            result.potassium_pulse == PULSE_PARK)
        else $error("alarm did not park nutrient pumps");

    a_idle_water_parked: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.pump_flags[0] |-> result.water_pulse == PULSE_PARK)
        else $error("stopped water pump not parked");

    a_state_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(active_reg[0]) && $stable(angle_reg[0]))
        else $error("pump state moved without a beat");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_reg[0] <= ANGLE_MAX && angle_reg[1] <= ANGLE_MAX &&
        angle_reg[2] <= ANGLE_MAX && angle_reg[3] <= ANGLE_MAX)
        else $error("sweep angle out of range");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> sample_ready)
        else $error("input register empty but sample not ready");

endmodule

// ===== sim/sphc_checker.sv =====
// sphc_checker: scoreboard for the soil pump hysteresis controller bench.
// Follows sample, result and register write beats, predicts every result and compares.
// Depends on sphc_pkg for the beat structs, register codes and constants.
module sphc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    input  logic                            sample_ready,
    input  sphc_pkg::sample_t               sample,
    input  logic                            result_valid,
    input  logic                            result_ready,
    input  sphc_pkg::result_t               result,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  sphc_pkg::cfg_index_t            cfg_index,
    input  logic [sphc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              outstanding,
    output int                              results_checked
);
    import sphc_pkg::*;

    localparam int STEP_DEG        = SWEEP_STEP;
    localparam int TOP_DEG         = ANGLE_MAX;
    localparam int PARK_DEG        = ANGLE_PARK;
    localparam int PARK_PULSE      = PULSE_PARK;
    localparam int BASE_PULSE      = PULSE_MIN;
    localparam int SPAN_PULSE      = 450;   // 600 minus 150 over the full sweep
    localparam int FULL_SCALE      = RAW_FULL;
    localparam int PUMP_NITROGEN   = 1;
    localparam int PUMP_PHOSPHORUS = 2;
    localparam int PUMP_POTASSIUM  = 3;

    int      lower_limit [NUM_PUMPS];
    int      moist_band;
    int      nutr_band;
    int      ph_floor;
    int      ph_ceil;
    bit      pump_on [NUM_PUMPS];
    int      sweep_deg [NUM_PUMPS];
    bit      sweep_down [NUM_PUMPS];
    result_t expected_q [$];
    int      errors;
    int      compared;

    function automatic int scaled(logic [11:0] raw, int full);
        return int'(raw) * full / FULL_SCALE;
    endfunction

    // Hysteresis, then one sweep step or park; gives the pulse count.
    function automatic int advance_pump(int k, int level, int lo, int band);
        int deg;
        if (level < lo)
            pump_on[k] = 1'b1;
        else if (level > lo + band)
            pump_on[k] = 1'b0;
        if (!pump_on[k])
        begin
            sweep_deg[k] = PARK_DEG;
            return PARK_PULSE;
        end
        deg = sweep_deg[k] + (sweep_down[k] ? -STEP_DEG : STEP_DEG);
        if (deg >= TOP_DEG)
        begin
            deg = TOP_DEG;
            sweep_down[k] = 1'b1;
        end
        else if (deg <= 0)
        begin
            deg = 0;
            sweep_down[k] = 1'b0;
        end
        sweep_deg[k] = deg;
        return BASE_PULSE + deg * SPAN_PULSE / TOP_DEG;
    endfunction

    function automatic result_t predict_reading(sample_t s);
        result_t r;
        int      level [NUM_PUMPS];
        int      pulse [NUM_PUMPS];
        int      acidity;
        bit      alarm;
        level[PUMP_WATER]      = scaled(s.raw_moisture, int'(FULL_PCT));
        level[PUMP_NITROGEN]   = scaled(s.raw_nitrogen, int'(FULL_NUT));
        level[PUMP_PHOSPHORUS] = scaled(s.raw_phosphorus, int'(FULL_NUT));
        level[PUMP_POTASSIUM]  = scaled(s.raw_potassium, int'(FULL_NUT));
        acidity = scaled(s.raw_acidity, int'(FULL_PH));
        // interlock acts before any pump update; nutrient sweep state holds
        alarm = (acidity < ph_floor) || (acidity > ph_ceil);
        if (alarm)
            for (int k = PUMP_NITROGEN; k < NUM_PUMPS; k++)
                pump_on[k] = 1'b0;
        pulse[PUMP_WATER] = advance_pump(PUMP_WATER, level[PUMP_WATER],
                                         lower_limit[PUMP_WATER], moist_band);
        for (int k = PUMP_NITROGEN; k < NUM_PUMPS; k++)
            pulse[k] = alarm ? PARK_PULSE
                             : advance_pump(k, level[k], lower_limit[k], nutr_band);
        r.moisture_pct     = 7'(level[PUMP_WATER]);
        r.acidity_tenths   = 8'(acidity);
        r.nitrogen_level   = 9'(level[PUMP_NITROGEN]);
        r.phosphorus_level = 9'(level[PUMP_PHOSPHORUS]);
        r.potassium_level  = 9'(level[PUMP_POTASSIUM]);
        r.alarm_on         = alarm;
        r.pump_flags       = {pump_on[PUMP_POTASSIUM], pump_on[PUMP_PHOSPHORUS],
                              pump_on[PUMP_NITROGEN], pump_on[PUMP_WATER]};
        r.water_pulse      = 10'(pulse[PUMP_WATER]);
        r.nitrogen_pulse   = 10'(pulse[PUMP_NITROGEN]);
        r.phosphorus_pulse = 10'(pulse[PUMP_PHOSPHORUS]);
        r.potassium_pulse  = 10'(pulse[PUMP_POTASSIUM]);
        return r;
    endfunction

    function automatic int field_differs(string name, logic [11:0] want, logic [11:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        int      bad;
        if (!rst_n)
        begin
            lower_limit[PUMP_WATER]      = int'(MOISTURE_MIN_RST);
            lower_limit[PUMP_NITROGEN]   = int'(NITROGEN_MIN_RST);
            lower_limit[PUMP_PHOSPHORUS] = int'(PHOSPHORUS_MIN_RST);
            lower_limit[PUMP_POTASSIUM]  = int'(POTASSIUM_MIN_RST);
            moist_band = int'(MOISTURE_BAND_RST);
            nutr_band  = int'(NUTRIENT_BAND_RST);
            ph_floor   = int'(PH_LOW_RST);
            ph_ceil    = int'(PH_HIGH_RST);
            for (int k = 0; k < NUM_PUMPS; k++)
            begin
                pump_on[k]    = 1'b0;
                sweep_deg[k]  = PARK_DEG;
                sweep_down[k] = 1'b0;
            end
            expected_q.delete();
            errors   = 0;
            compared = 0;
            fail_count      <= 0;
            outstanding     <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MOISTURE_MIN:   lower_limit[PUMP_WATER] = int'(cfg_data[6:0]);
                    REG_NITROGEN_MIN:   lower_limit[PUMP_NITROGEN] = int'(cfg_data);
                    REG_PHOSPHORUS_MIN: lower_limit[PUMP_PHOSPHORUS] = int'(cfg_data);
                    REG_POTASSIUM_MIN:  lower_limit[PUMP_POTASSIUM] = int'(cfg_data);
                    REG_MOISTURE_BAND:  moist_band = int'(cfg_data[6:0]);
                    REG_NUTRIENT_BAND:  nutr_band = int'(cfg_data);
                    REG_PH_LOW_TENTHS:  ph_floor = int'(cfg_data[7:0]);
                    REG_PH_HIGH_TENTHS: ph_ceil = int'(cfg_data[7:0]);
                    default: ;
                endcase
            end
            if (result_valid && result_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %h", $time, result);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    bad = 0;
                    bad += field_differs("moisture_pct", want.moisture_pct, result.moisture_pct);
                    bad += field_differs("acidity_tenths", want.acidity_tenths,
                                         result.acidity_tenths);
                    bad += field_differs("nitrogen_level", want.nitrogen_level,
                                         result.nitrogen_level);
                    bad += field_differs("phosphorus_level", want.phosphorus_level,
                                         result.phosphorus_level);
                    bad += field_differs("potassium_level", want.potassium_level,
                                         result.potassium_level);
                    bad += field_differs("alarm_on", want.alarm_on, result.alarm_on);
                    bad += field_differs("pump_flags", want.pump_flags, result.pump_flags);
                    bad += field_differs("water_pulse", want.water_pulse, result.water_pulse);
                    bad += field_differs("nitrogen_pulse", want.nitrogen_pulse,
                                         result.nitrogen_pulse);
                    bad += field_differs("phosphorus_pulse", want.phosphorus_pulse,
                                         result.phosphorus_pulse);
                    bad += field_differs("potassium_pulse", want.potassium_pulse,
                                         result.potassium_pulse);
                    errors += bad;
                    compared++;
                end
            end
            if (sample_valid && sample_ready)
                expected_q.push_back(predict_reading(sample));
            fail_count      <= errors;
            outstanding     <= expected_q.size();
            results_checked <= compared;
        end
    end

endmodule

// ===== sim/soil_pump_hysteresis_controller_tb.sv =====
// soil_pump_hysteresis_controller_tb: top of the controller bench; clock, reset, stimulus, verdict.
// Depends on sphc_pkg, sphc_checker and the soil_pump_hysteresis_controller RTL.
module soil_pump_hysteresis_controller_tb;
    import sphc_pkg::*;

    // Run shape
    localparam int BLOCK_ITEMS    = 78;    // random sample beats per register setting
    localparam int NOISE_PCT      = 15;    // share of fully random beats
    localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles before giving up
    localparam int SETTLE_CYCLES  = 8;     // idle margin after the last drain

    // Register setting plans; the rest are random but sensible
    localparam int PLAN_RESET    = 0;
    localparam int PLAN_TOP      = 1;
    localparam int PLAN_ZERO     = 4;
    localparam int PLAN_WIDE     = 7;
    localparam int PLAN_INVERTED = 10;

    localparam int WALK_MOISTURE = 0;
    localparam int WALK_ACIDITY  = 1;
    localparam int WALK_NITROGEN = 2;
    localparam int WALK_PHOSPHOR = 3;
    localparam int WALK_POTASSIUM = 4;

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_ready;
    sample_t               sample;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int outstanding;
    int results_checked;

    // Pacing: percent of cycles the sender idles and the receiver stalls
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int idle_plan [4]  = '{0, 79, 0, 23};
    int stall_plan [4] = '{0, 0, 79, 23};

    int samples_sent     = 0;
    int settings_applied = 0;
    int quiet_cycles     = 0;

    logic [CFG_DATA_W-1:0] setting_word [8];
    logic [11:0]           drift [5];   // slowly wandering sensor readings

    soil_pump_hysteresis_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Scoreboard: sees every beat, keeps its own copy of pump state and registers
    sphc_checker scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver back-pressure, re-rolled every cycle
    always @(posedge clk)
        result_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);

    // Watchdog: any accepted beat on any channel counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Smallest raw reading that scales to the wanted value
    function automatic logic [11:0] raw_for(int target, int full);
        int raw;
        raw = (target * int'(RAW_FULL) + full - 1) / full;
        if (raw > int'(RAW_FULL))
            raw = int'(RAW_FULL);
        return 12'(raw);
    endfunction

    function automatic logic [11:0] wander(logic [11:0] cur, int reach);
        int v;
        v = int'(cur) + int'($urandom_range(0, 2 * reach)) - reach;
        if (v < 0)
            v = 0;
        else if (v > int'(RAW_FULL))
            v = int'(RAW_FULL);
        return 12'(v);
    endfunction

    // Mostly drifting readings so pumps stay on long enough to sweep, some pure noise
    function automatic sample_t next_sample();
        sample_t s;
        if ($urandom_range(0, 99) < NOISE_PCT)
        begin
            s = 60'({$urandom, $urandom});
            return s;
        end
        drift[WALK_MOISTURE]  = wander(drift[WALK_MOISTURE], 120);
        drift[WALK_ACIDITY]   = wander(drift[WALK_ACIDITY], 60);
        drift[WALK_NITROGEN]  = wander(drift[WALK_NITROGEN], 150);
        drift[WALK_PHOSPHOR]  = wander(drift[WALK_PHOSPHOR], 150);
        drift[WALK_POTASSIUM] = wander(drift[WALK_POTASSIUM], 150);
        s.raw_moisture   = drift[WALK_MOISTURE];
        s.raw_acidity    = drift[WALK_ACIDITY];
        s.raw_nitrogen   = drift[WALK_NITROGEN];
        s.raw_phosphorus = drift[WALK_PHOSPHOR];
        s.raw_potassium  = drift[WALK_POTASSIUM];
        return s;
    endfunction

    // Valid is only dropped when a gap is taken, so back-to-back beats keep it high
    task automatic send_sample(input sample_t s);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        sample       <= s;
        sample_valid <= 1'b1;
        do @(posedge clk); while (!sample_ready);
        samples_sent++;
    endtask

    task automatic send_scaled(input int moist, input int ph, input int n, input int p,
                               input int k);
        sample_t s;
        s.raw_moisture   = raw_for(moist, int'(FULL_PCT));
        s.raw_acidity    = raw_for(ph, int'(FULL_PH));
        s.raw_nitrogen   = raw_for(n, int'(FULL_NUT));
        s.raw_phosphorus = raw_for(p, int'(FULL_NUT));
        s.raw_potassium  = raw_for(k, int'(FULL_NUT));
        send_sample(s);
    endtask

    // Stop sending and wait until every predicted result has come back.
    // The first edge lets the checker count a beat accepted at this very edge.
    task automatic drain_results();
        sample_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic choose_settings(input int plan);
        int lo;
        setting_word[REG_MOISTURE_MIN]   = 9'($urandom_range(20, 80));
        setting_word[REG_NITROGEN_MIN]   = 9'($urandom_range(50, 400));
        setting_word[REG_PHOSPHORUS_MIN] = 9'($urandom_range(50, 400));
        setting_word[REG_POTASSIUM_MIN]  = 9'($urandom_range(50, 400));
        setting_word[REG_MOISTURE_BAND]  = 9'($urandom_range(0, 25));
        setting_word[REG_NUTRIENT_BAND]  = 9'($urandom_range(0, 80));
        lo = int'($urandom_range(30, 70));
        setting_word[REG_PH_LOW_TENTHS]  = 9'(lo);
        setting_word[REG_PH_HIGH_TENTHS] = 9'(lo + int'($urandom_range(0, 50)));
        case (plan)
            PLAN_RESET:
            begin
                setting_word[REG_MOISTURE_MIN]   = 9'(MOISTURE_MIN_RST);
                setting_word[REG_NITROGEN_MIN]   = NITROGEN_MIN_RST;
                setting_word[REG_PHOSPHORUS_MIN] = PHOSPHORUS_MIN_RST;
                setting_word[REG_POTASSIUM_MIN]  = POTASSIUM_MIN_RST;
                setting_word[REG_MOISTURE_BAND]  = 9'(MOISTURE_BAND_RST);
                setting_word[REG_NUTRIENT_BAND]  = NUTRIENT_BAND_RST;
                setting_word[REG_PH_LOW_TENTHS]  = 9'(PH_LOW_RST);
                setting_word[REG_PH_HIGH_TENTHS] = 9'(PH_HIGH_RST);
            end
            PLAN_TOP:
            begin
                // widest thresholds, pH window open end to end
                setting_word[REG_MOISTURE_MIN]   = 9'd100;
                setting_word[REG_NITROGEN_MIN]   = 9'd500;
                setting_word[REG_PHOSPHORUS_MIN] = 9'd500;
                setting_word[REG_POTASSIUM_MIN]  = 9'd500;
                setting_word[REG_MOISTURE_BAND]  = 9'd100;
                setting_word[REG_NUTRIENT_BAND]  = 9'd500;
                setting_word[REG_PH_LOW_TENTHS]  = 9'd0;
                setting_word[REG_PH_HIGH_TENTHS] = 9'd140;
            end
            PLAN_ZERO:
            begin
                foreach (setting_word[i])
                    setting_word[i] = '0;
            end
            PLAN_WIDE:
            begin
                // beyond the documented ranges; the block keeps only its width
                foreach (setting_word[i])
                    setting_word[i] = '1;
            end
            PLAN_INVERTED:
            begin
                setting_word[REG_PH_LOW_TENTHS]  = 9'd100;
                setting_word[REG_PH_HIGH_TENTHS] = 9'd40;
            end
            default: ;
        endcase
    endtask

    // All eight registers back to back, valid held high across them
    task automatic program_settings();
        cfg_index_t idx;
        idx = idx.first();
        repeat (idx.num())
        begin
            cfg_index <= idx;
            cfg_data  <= setting_word[idx];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_MOISTURE_MIN;
        cfg_data     <= '0;
        foreach (drift[i])
            drift[i] = 12'd2048;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset register values (moisture 60+10, N/K 100+30,
        // P 50+30, pH window 5.0 to 8.0)
        send_sample('0);                     // everything at zero: alarm, water on
        send_sample('1);                     // full scale: alarm, water off
        repeat (8)
            send_scaled(30, 65, 10, 10, 10); // all pumps on, sweep runs into 180 and back
        send_scaled(70, 50, 130, 80, 130);   // levels at min plus band hold; pH at low edge
        send_scaled(60, 80, 100, 50, 100);   // levels at min hold; pH at high edge
        send_scaled(60, 49, 100, 50, 100);   // pH just below window: nutrients stop, freeze
        send_scaled(60, 81, 0, 0, 0);        // just above window, alarm wins over low levels
        send_scaled(71, 65, 131, 81, 131);   // just above the bands: every pump off
        send_scaled(20, 65, 0, 0, 0);        // back on, sweep keeps its old direction
        send_sample({12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA});
        send_sample({12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555});

        // Random part: four pacing modes, three register settings each
        for (int mode = 0; mode < 4; mode++)
        begin
            for (int blk = 0; blk < 3; blk++)
            begin
                drain_results();
                send_idle_pct <= idle_plan[mode];
                stall_pct     <= stall_plan[mode];
                choose_settings(mode * 3 + blk);
                program_settings();
                for (int n = 0; n < BLOCK_ITEMS; n++)
                begin
                    // halfway through, hold off until the pipeline is empty
                    if (n == BLOCK_ITEMS / 2)
                        drain_results();
                    send_sample(next_sample());
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d sample beats over %0d register settings and four pacing modes",
                 samples_sent, settings_applied);
        $display("%0d result beats compared, %0d field mismatches", results_checked, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
